/* design/ifp_pkg.sv */
// Package for the IMU serial frame parser: field widths, frame constants,
// result kind codes and register indexes. No dependencies.
`default_nettype none

package ifp_pkg;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 21;
    localparam int KIND_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int ACCEL_FS_W = 7;
    localparam int GYRO_FS_W  = 12;
    localparam int ANGLE_FS_W = 9;

    localparam int HOLD_LEN = 10;
    localparam int FILL_W   = 4;

    localparam logic [BYTE_W-1:0] HDR_SYNC  = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_MASK  = 8'h50;
    localparam logic [BYTE_W-1:0] TYPE_ACCEL = 8'h51;
    localparam logic [BYTE_W-1:0] TYPE_GYRO  = 8'h52;
    localparam logic [BYTE_W-1:0] TYPE_ANGLE = 8'h53;

    localparam logic [ACCEL_FS_W-1:0] ACCEL_FS_RESET = 7'd16;
    localparam logic [GYRO_FS_W-1:0]  GYRO_FS_RESET  = 12'd2000;
    localparam logic [ANGLE_FS_W-1:0] ANGLE_FS_RESET = 9'd180;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEL   = 3'd0,
        KIND_GYRO    = 3'd1,
        KIND_ANGLE   = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_SLIP    = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_FS = 2'd0,
        REG_GYRO_FS  = 2'd1,
        REG_ANGLE_FS = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

/* design/ifp_if.sv */
// Channel interfaces of the IMU serial frame parser: byte input, result
// output and configuration write. Depends on ifp_pkg.
`default_nettype none

interface ifp_byte_if;
    logic                      valid;
    logic                      ready;
    logic [ifp_pkg::BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface ifp_result_if;
    logic                               valid;
    logic                               ready;
    logic [ifp_pkg::KIND_W-1:0]         kind;
    logic signed [ifp_pkg::VALUE_W-1:0] value_x;
    logic signed [ifp_pkg::VALUE_W-1:0] value_y;
    logic signed [ifp_pkg::VALUE_W-1:0] value_z;

    modport source (output valid, output kind, output value_x, output value_y,
                    output value_z, input ready);
    modport sink   (input valid, input kind, input value_x, input value_y,
                    input value_z, output ready);
endinterface

interface ifp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ifp_pkg::CFG_IDX_W-1:0]  index;
    logic [ifp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/imu_serial_frame_parser_core.sv */
// IMU serial frame parser, top level: byte window, header check and axis scaling.
// Depends on ifp_pkg and the channel interfaces in ifp_if.
// A result is built from the full window when the byte in the input register meets
// it (input register, then result register). Throughput: one byte per cycle; only a
// byte that meets a full window stalls, while the result register is full and not taken.
// Reset (synchronous, active low) empties the window and both stages and loads default scales.
`default_nettype none

module imu_serial_frame_parser_core (
    input  wire             i_clk,
    input  wire             i_rst_n,
    ifp_cfg_if.sink         i_cfg,
    ifp_byte_if.sink        i_byte,
    ifp_result_if.source    o_result
);

    // Configuration registers. Writes are always taken; an index past the
    // list is accepted and ignored.
    logic [ifp_pkg::ACCEL_FS_W-1:0] r_accel_fs;
    logic [ifp_pkg::GYRO_FS_W-1:0]  r_gyro_fs;
    logic [ifp_pkg::ANGLE_FS_W-1:0] r_angle_fs;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_fs <= ifp_pkg::ACCEL_FS_RESET;
            r_gyro_fs  <= ifp_pkg::GYRO_FS_RESET;
            r_angle_fs <= ifp_pkg::ANGLE_FS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ifp_pkg::REG_ACCEL_FS: r_accel_fs <= i_cfg.data[ifp_pkg::ACCEL_FS_W-1:0];
                ifp_pkg::REG_GYRO_FS:  r_gyro_fs  <= i_cfg.data[ifp_pkg::GYRO_FS_W-1:0];
                ifp_pkg::REG_ANGLE_FS: r_angle_fs <= i_cfg.data[ifp_pkg::ANGLE_FS_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register. The byte waits here before the decode
    // stage looks at it together with the held window.
    logic                        r_s1_valid;
    logic [ifp_pkg::BYTE_W-1:0]  r_s1_byte;

    // Window of held bytes, oldest first, and the number of bytes held.
    logic [ifp_pkg::BYTE_W-1:0]  r_win [ifp_pkg::HOLD_LEN];
    logic [ifp_pkg::FILL_W-1:0]  r_fill;

    // Result register.
    logic                                r_out_valid;
    logic [ifp_pkg::KIND_W-1:0]          r_out_kind;
    logic signed [ifp_pkg::VALUE_W-1:0]  r_out_x;
    logic signed [ifp_pkg::VALUE_W-1:0]  r_out_y;
    logic signed [ifp_pkg::VALUE_W-1:0]  r_out_z;

    // A byte that only fills the window gives no result and may pass even
    // while the result register is blocked. A byte on a full window always
    // gives one result and needs the result register free.
    logic win_full;
    logic out_free;
    logic advance;

    assign win_full = (r_fill == ifp_pkg::FILL_W'(ifp_pkg::HOLD_LEN));
    assign out_free = !r_out_valid || o_result.ready;
    assign advance  = r_s1_valid && (!win_full || out_free);

    assign i_byte.ready = !r_s1_valid || advance;

    // Header check on the two oldest held bytes.
    logic hdr_ok;
    assign hdr_ok = (r_win[0] == ifp_pkg::HDR_SYNC)
                 && ((r_win[1] & ifp_pkg::HDR_MASK) == ifp_pkg::HDR_MASK);

    // Frame type selects the kind and the full scale. All scales are widened
    // to the gyro width so that one multiplier form serves every type.
    ifp_pkg::t_kind                 type_kind;
    logic [ifp_pkg::GYRO_FS_W-1:0]  sel_fs;

    always_comb begin
        case (r_win[1])
            ifp_pkg::TYPE_ACCEL: begin
                type_kind = ifp_pkg::KIND_ACCEL;
                sel_fs    = ifp_pkg::GYRO_FS_W'(r_accel_fs);
            end
            ifp_pkg::TYPE_GYRO: begin
                type_kind = ifp_pkg::KIND_GYRO;
                sel_fs    = r_gyro_fs;
            end
            ifp_pkg::TYPE_ANGLE: begin
                type_kind = ifp_pkg::KIND_ANGLE;
                sel_fs    = ifp_pkg::GYRO_FS_W'(r_angle_fs);
            end
            default: begin
                type_kind = ifp_pkg::KIND_UNKNOWN;
                sel_fs    = '0;
            end
        endcase
    end

    // Axis scaling: raw * full_scale / 128 with floor. The arithmetic shift
    // by seven is the floor division; the 21 bits above it always hold the
    // whole quotient because the product stays below 2^27 in magnitude.
    localparam int RAW_W  = 16;
    localparam int PROD_W = RAW_W + ifp_pkg::GYRO_FS_W + 1;
    localparam int SHIFT  = 7;

    logic signed [RAW_W-1:0]  raw_x, raw_y, raw_z;
    logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
    logic signed [ifp_pkg::GYRO_FS_W:0] fs_s;

    assign raw_x = $signed({r_win[3], r_win[2]});
    assign raw_y = $signed({r_win[5], r_win[4]});
    assign raw_z = $signed({r_win[7], r_win[6]});
    assign fs_s  = $signed({1'b0, sel_fs});

    assign prod_x = PROD_W'(raw_x) * PROD_W'(fs_s);
    assign prod_y = PROD_W'(raw_y) * PROD_W'(fs_s);
    assign prod_z = PROD_W'(raw_z) * PROD_W'(fs_s);

    // Next result, valid only when the window was full.
    logic [ifp_pkg::KIND_W-1:0]          n_out_kind;
    logic signed [ifp_pkg::VALUE_W-1:0]  n_out_x;
    logic signed [ifp_pkg::VALUE_W-1:0]  n_out_y;
    logic signed [ifp_pkg::VALUE_W-1:0]  n_out_z;

    always_comb begin
        n_out_kind = ifp_pkg::KIND_SLIP;
        n_out_x    = '0;
        n_out_y    = '0;
        n_out_z    = '0;
        if (hdr_ok) begin
            n_out_kind = type_kind;
            if (type_kind != ifp_pkg::KIND_UNKNOWN) begin
                n_out_x = prod_x[SHIFT +: ifp_pkg::VALUE_W];
                n_out_y = prod_y[SHIFT +: ifp_pkg::VALUE_W];
                n_out_z = prod_z[SHIFT +: ifp_pkg::VALUE_W];
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_byte.ready) begin
                r_s1_valid <= i_byte.valid;
            end

            if (advance && win_full) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                if (!win_full) begin
                    r_fill <= r_fill + 1'b1;
                end else if (hdr_ok) begin
                    // A passed header empties the window; a slip keeps it full.
                    r_fill <= '0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_s1_byte <= i_byte.byte_in;
        end

        if (advance) begin
            if (!win_full) begin
                r_win[r_fill] <= r_s1_byte;
            end else if (!hdr_ok) begin
                // Slip: drop the oldest byte and append the new one.
                for (int i = 0; i < ifp_pkg::HOLD_LEN - 1; i++) begin
                    r_win[i] <= r_win[i + 1];
                end
                r_win[ifp_pkg::HOLD_LEN - 1] <= r_s1_byte;
            end
        end

        if (advance && win_full) begin
            r_out_kind <= n_out_kind;
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_z    <= n_out_z;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.kind    = r_out_kind;
    assign o_result.value_x = r_out_x;
    assign o_result.value_y = r_out_y;
    assign o_result.value_z = r_out_z;

endmodule

`default_nettype wire
